FILE: sv/transfer_table_interpolator_assert.svh
// Assertion macros used by the transfer table interpolator checker
`ifndef TRANSFER_TABLE_INTERPOLATOR_ASSERT_SVH
`define TRANSFER_TABLE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tti assertion failed");

// next-cycle implication
`define TTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tti assertion failed");

`endif

FILE: sv/tti_pkg.sv
// Types and constants of the transfer table interpolator
`timescale 1ns / 1ps
package tti_pkg;

  localparam int COORD_W    = 12;
  localparam int SLOT_W     = 4;
  localparam int LEVEL_W    = 8;
  localparam int OPAC_W     = 17;
  localparam int COUNT_W    = 5;
  localparam int AREA_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int X_W        = 13;
  localparam int FRAC_W     = 16;
  localparam int FDIV_STEPS = AREA_W + FRAC_W;

  // floor(p / 254) == (p * RECIP_254) >> RECIP_SHIFT for p below 2^21
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_254 = 21'd1056833;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic CURVE_LINEAR = 1'b0;
  localparam logic CURVE_CUBIC  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_RESERVED = 8'd255;
  localparam logic [OPAC_W-1:0]  OPAC_ONE       = 17'd65536;

  typedef struct packed {
    logic                func;
    logic [SLOT_W-1:0]   point_slot;
    logic [COORD_W-1:0]  point_x;
    logic [COORD_W-1:0]  point_y;
    logic [LEVEL_W-1:0]  level;
  } tti_in_t;

  typedef struct packed {
    logic [OPAC_W-1:0]   opacity;
    logic [LEVEL_W-1:0]  level_echo;
  } tti_out_t;

endpackage

FILE: sv/tti_stream_if.sv
// Valid/ready stream interface carrying one payload per beat
`timescale 1ns / 1ps
interface tti_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/tti_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tti_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/tti_div.sv
// Restoring divider, one quotient bit per cycle, numerator taken MSB first
`timescale 1ns / 1ps
module tti_div #(
  parameter int NUM_W = 55,
  parameter int DEN_W = 36
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [$clog2(NUM_W+1)-1:0] steps,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [NUM_W-1:0]           quot,
  output logic                       rem_nz
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = |rem_r;
endmodule

FILE: sv/transfer_table_interpolator.sv
// Transfer table interpolator top level
// Control points live in a small RAM; a load beat to a slot below MAX_POINTS writes one point.
// An evaluate beat maps its level onto the x axis, walks the points in order (one RAM
// read per point, one point per cycle) to find the segment, forms the linear or
// zero-slope cubic term with a few registered multiplies, and divides through one shared
// restoring divider at one bit per cycle. The curve pass of the divider, when taken,
// divides the PW-bit product (55 bits at 12-bit coordinates); a second pass forms the
// opacity fraction. Input ready returns in the same cycle that the result turns valid.
// A load gives no result and leaves the block idle and ready for the next beat.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps
module transfer_table_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tti_stream_if.sink                       in_ch,
  tti_stream_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [tti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tti_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tti_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = AW + 1;
  localparam int CB   = COORD_W;
  localparam int EW   = (CB > X_W) ? CB : X_W;
  localparam int DW   = EW + 1;
  localparam int TW   = EW + 4;
  localparam int QW   = 2 * EW + TW;
  localparam int QHI  = QW - 32;
  localparam int PW   = QW + CB;
  localparam int YW   = PW + 3;
  localparam int DENW = 3 * CB;
  localparam int SLW  = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int CNW  = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int STW  = $clog2(PW + 1);
  localparam int PRW  = LEVEL_W + AREA_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAP1   = 4'd1;
  localparam logic [3:0] S_MAP2   = 4'd2;
  localparam logic [3:0] S_SEARCH = 4'd3;
  localparam logic [3:0] S_SETUP  = 4'd4;
  localparam logic [3:0] S_MUL1   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_MAG    = 4'd7;
  localparam logic [3:0] S_PPLO   = 4'd8;
  localparam logic [3:0] S_PPHI   = 4'd9;
  localparam logic [3:0] S_SDIV   = 4'd10;
  localparam logic [3:0] S_SWAIT  = 4'd11;
  localparam logic [3:0] S_CLAMP  = 4'd12;
  localparam logic [3:0] S_FDIV   = 4'd13;
  localparam logic [3:0] S_FWAIT  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  // control
  logic [3:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] point_count_r;
  logic               curve_mode_r;
  logic [AREA_W-1:0]  width_r;
  logic [AREA_W-1:0]  height_r;
  logic               out_valid_r, out_valid_nxt;
  logic [NW-1:0]      k_r, k_nxt;

  // datapath
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic [PRW-1:0]           prod_r, prod_nxt;
  logic [X_W-1:0]           x_r, x_nxt;
  logic [NW-1:0]            n_r, n_nxt;
  logic [2*CB-1:0]          prev_r, prev_nxt;
  logic [2*CB-1:0]          cur_r, cur_nxt;
  logic [CB-1:0]            y1_r, y1_nxt;
  logic [CB-1:0]            d_r, d_nxt;
  logic signed [DW-1:0]     u_r, u_nxt;
  logic signed [DW-1:0]     dy_r, dy_nxt;
  logic [2*EW-1:0]          usq_r, usq_nxt;
  logic [2*CB-1:0]          dsq_r, dsq_nxt;
  logic signed [QW-1:0]     q_r, q_nxt;
  logic [DENW-1:0]          den_r, den_nxt;
  logic [QW-1:0]            qmag_r, qmag_nxt;
  logic [CB-1:0]            dymag_r, dymag_nxt;
  logic                     neg_r, neg_nxt;
  logic [PW-1:0]            acc_r, acc_nxt;
  logic signed [YW-1:0]     yraw_r, yraw_nxt;
  logic [AREA_W-1:0]        y_r, y_nxt;
  logic [OPAC_W-1:0]        opac_r, opac_nxt;
  logic [OPAC_W-1:0]        out_opac_r, out_opac_nxt;
  logic [LEVEL_W-1:0]       out_level_r, out_level_nxt;

  // RAM and divider
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [2*CB-1:0]    ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [2*CB-1:0]    ram_rdata;
  logic               div_start;
  logic [STW-1:0]     div_steps;
  logic [PW-1:0]      div_num;
  logic [DENW-1:0]    div_den;
  logic               div_done;
  logic [PW-1:0]      div_quot;
  logic               div_rem_nz;

  // helpers
  logic                    in_fire;
  logic [SLW-1:0]          slot_ext;
  logic [CNW-1:0]          pc_ext;
  logic [NW-1:0]           k_plus;
  logic [PRW+RECIP_W-1:0]  xprod;
  logic [CB-1:0]           rx, x1, y1, x2, y2;
  logic signed [DW-1:0]    d_s, u_s, dy_s;
  logic signed [TW-1:0]    t3;
  logic signed [2*DW-1:0]  usq_full;
  logic signed [QW:0]      q_full;
  logic [QHI+CB-1:0]       pp_hi;
  logic [YW-1:0]           qe;
  logic signed [YW-1:0]    vs;
  logic [PW-1:0]           fnum;
  logic                    out_free;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_ext  = SLW'(in_ch.payload.point_slot);
  assign ram_we    = in_fire && (in_ch.payload.func == FUNC_LOAD) &&
                     (slot_ext < SLW'(MAX_POINTS));
  assign ram_waddr = slot_ext[AW-1:0];
  assign ram_wdata = {CB'(in_ch.payload.point_y), CB'(in_ch.payload.point_x)};
  assign k_plus    = k_r + 1'b1;
  assign ram_raddr = (state_r == S_MAP2) ? '0 : k_plus[AW-1:0];

  tti_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fnum      = PW'({height_r - y_r, {FRAC_W{1'b0}}}) << (PW - FDIV_STEPS);
  assign div_start = (state_r == S_SDIV) || (state_r == S_FDIV);
  assign div_num   = (state_r == S_FDIV) ? fnum : acc_r;
  assign div_den   = (state_r == S_FDIV) ? DENW'(height_r) : den_r;
  assign div_steps = (state_r == S_FDIV) ? STW'(FDIV_STEPS) : STW'(PW);

  tti_div #(.NUM_W(PW), .DEN_W(DENW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .steps  (div_steps),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_quot),
    .rem_nz (div_rem_nz)
  );

  assign pc_ext   = CNW'(point_count_r);
  assign xprod    = prod_r * RECIP_254;
  assign rx       = ram_rdata[CB-1:0];
  assign x1       = prev_r[CB-1:0];
  assign y1       = prev_r[2*CB-1:CB];
  assign x2       = cur_r[CB-1:0];
  assign y2       = cur_r[2*CB-1:CB];
  assign d_s      = $signed(DW'(x2)) - $signed(DW'(x1));
  assign u_s      = $signed(DW'(x_r)) - $signed(DW'(x1));
  assign dy_s     = $signed(DW'(y2)) - $signed(DW'(y1));
  assign t3       = ($signed(TW'(d_r)) <<< 1) + $signed(TW'(d_r)) -
                    ($signed({{(TW-DW){u_r[DW-1]}}, u_r}) <<< 1);
  assign usq_full = u_r * u_r;
  assign q_full   = $signed({1'b0, usq_r}) * t3;
  assign pp_hi    = qmag_r[QW-1:32] * dymag_r;
  assign qe       = YW'(div_quot) + YW'(neg_r && div_rem_nz);
  assign vs       = neg_r ? -$signed(qe) : $signed(qe);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    level_nxt     = level_r;
    prod_nxt      = prod_r;
    x_nxt         = x_r;
    n_nxt         = n_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    y1_nxt        = y1_r;
    d_nxt         = d_r;
    u_nxt         = u_r;
    dy_nxt        = dy_r;
    usq_nxt       = usq_r;
    dsq_nxt       = dsq_r;
    q_nxt         = q_r;
    den_nxt       = den_r;
    qmag_nxt      = qmag_r;
    dymag_nxt     = dymag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    yraw_nxt      = yraw_r;
    y_nxt         = y_r;
    opac_nxt      = opac_r;
    out_opac_nxt  = out_opac_r;
    out_level_nxt = out_level_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.payload.func == FUNC_EVAL)) begin
          level_nxt = in_ch.payload.level;
          state_nxt = S_MAP1;
        end
      end
      S_MAP1: begin
        prod_nxt = PRW'(level_r * width_r);
        n_nxt    = (pc_ext > CNW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(pc_ext);
        if ((level_r == LEVEL_RESERVED) || (height_r == '0)) begin
          opac_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MAP2;
        end
      end
      S_MAP2: begin
        x_nxt = xprod[RECIP_SHIFT +: X_W];
        k_nxt = '0;
        if (n_r < NW'(2)) begin
          yraw_nxt  = '0;
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (k_r == '0) begin
          prev_nxt = ram_rdata;
          k_nxt    = k_plus;
        end else if (EW'(x_r) <= EW'(rx)) begin
          cur_nxt   = ram_rdata;
          state_nxt = S_SETUP;
        end else if (k_plus == n_r) begin
          yraw_nxt  = '0;
          state_nxt = S_CLAMP;
        end else begin
          prev_nxt = ram_rdata;
          k_nxt    = k_plus;
        end
      end
      S_SETUP: begin
        y1_nxt = y1;
        if (d_s == '0) begin
          yraw_nxt  = YW'(y1);
          state_nxt = S_CLAMP;
        end else if (d_s < 0) begin
          d_nxt     = CB'(-d_s);
          u_nxt     = -u_s;
          dy_nxt    = -dy_s;
          state_nxt = S_MUL1;
        end else begin
          d_nxt     = CB'(d_s);
          u_nxt     = u_s;
          dy_nxt    = dy_s;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        usq_nxt   = usq_full[2*EW-1:0];
        dsq_nxt   = d_r * d_r;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (curve_mode_r == CURVE_CUBIC) begin
          q_nxt   = q_full[QW-1:0];
          den_nxt = DENW'(dsq_r * d_r);
        end else begin
          q_nxt   = {{(QW-DW){u_r[DW-1]}}, u_r};
          den_nxt = DENW'(d_r);
        end
        state_nxt = S_MAG;
      end
      S_MAG: begin
        qmag_nxt  = q_r[QW-1] ? QW'(-q_r) : QW'(q_r);
        dymag_nxt = dy_r[DW-1] ? CB'(-dy_r) : CB'(dy_r);
        neg_nxt   = q_r[QW-1] ^ dy_r[DW-1];
        state_nxt = S_PPLO;
      end
      S_PPLO: begin
        acc_nxt   = PW'(qmag_r[31:0] * dymag_r);
        state_nxt = S_PPHI;
      end
      S_PPHI: begin
        acc_nxt   = acc_r + (PW'(pp_hi) << 32);
        state_nxt = S_SDIV;
      end
      S_SDIV: begin
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_done) begin
          yraw_nxt  = $signed(YW'(y1_r)) + vs;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (yraw_r < 0) begin
          y_nxt = '0;
        end else if (yraw_r > $signed(YW'(height_r))) begin
          y_nxt = height_r;
        end else begin
          y_nxt = yraw_r[AREA_W-1:0];
        end
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          opac_nxt  = div_quot[OPAC_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_opac_nxt  = opac_r;
          out_level_nxt = level_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
      point_count_r <= '0;
      curve_mode_r  <= CURVE_CUBIC;
      width_r       <= 12'd255;
      height_r      <= 12'd255;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: point_count_r <= cfg_data[COUNT_W-1:0];
          REG_CURVE_MODE:  curve_mode_r  <= cfg_data[0];
          REG_AREA_WIDTH:  width_r       <= cfg_data[AREA_W-1:0];
          REG_AREA_HEIGHT: height_r      <= cfg_data[AREA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    prod_r      <= prod_nxt;
    x_r         <= x_nxt;
    n_r         <= n_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    y1_r        <= y1_nxt;
    d_r         <= d_nxt;
    u_r         <= u_nxt;
    dy_r        <= dy_nxt;
    usq_r       <= usq_nxt;
    dsq_r       <= dsq_nxt;
    q_r         <= q_nxt;
    den_r       <= den_nxt;
    qmag_r      <= qmag_nxt;
    dymag_r     <= dymag_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    yraw_r      <= yraw_nxt;
    y_r         <= y_nxt;
    opac_r      <= opac_nxt;
    out_opac_r  <= out_opac_nxt;
    out_level_r <= out_level_nxt;
  end

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.payload.opacity     = out_opac_r;
  assign out_ch.payload.level_echo  = out_level_r;
endmodule

FILE: sv/tti_chk.sv
// Port-level checker for the transfer table interpolator, with its bind
`timescale 1ns / 1ps
module tti_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_func,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tti_pkg::OPAC_W-1:0]   out_opacity,
  input logic [tti_pkg::LEVEL_W-1:0]  out_level_echo
);
  import tti_pkg::*;
  `include "transfer_table_interpolator_assert.svh"

  // a stalled result beat holds
  `TTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_opacity) && $stable(out_level_echo))
  // an evaluate beat occupies the block
  `TTI_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && (in_func == FUNC_EVAL), !in_ready)
  // results only appear out of a busy cycle
  `TTI_ASSERT_IMPL(a_rise_busy, $rose(out_valid), !$past(in_ready))
  `TTI_ASSERT_IMPL(a_reserved, out_valid && (out_level_echo == LEVEL_RESERVED), out_opacity == '0)
  `TTI_ASSERT_IMPL(a_range, out_valid, out_opacity <= OPAC_ONE)
endmodule

bind transfer_table_interpolator tti_chk u_tti_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_func        (in_ch.payload.func),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_opacity    (out_ch.payload.opacity),
  .out_level_echo (out_ch.payload.level_echo)
);
